@@ rtl/keypad_code_sequence_lock_unit_assert.svh @@
// assertion macros shared by the lock unit
`ifndef KEYPAD_CODE_SEQUENCE_LOCK_UNIT_ASSERT_SVH
`define KEYPAD_CODE_SEQUENCE_LOCK_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define KCSL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kcsl same-cycle check failed");

// next-cycle implication
`define KCSL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kcsl next-cycle check failed");

`else

`define KCSL_ASSERT_IMP(label, clk, rst, ante, cons)
`define KCSL_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/kcsl_pkg.sv @@
package kcsl_pkg;

  localparam int PAD_COUNT  = 5;
  localparam int TIMER_BITS = 16;
  localparam int CODE_LEN   = 5;
  localparam int TICKS_W    = 16;
  localparam int CODE_W     = 3;
  localparam int COUNT_W    = 3;
  localparam int RED_W      = 5;
  localparam int PADS_W     = 5;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef logic [PAD_COUNT-1:0]  pad_mask_t;
  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CODE_W-1:0]     code_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [TICKS_W-1:0]    ticks_t;
  typedef logic [RED_W-1:0]      red_field_t;
  typedef logic [PADS_W-1:0]     pads_field_t;

  localparam timer_t    TIMER_MAX = '1;
  localparam pad_mask_t ALL_PADS  = '1;

  localparam ticks_t BEEP_TICKS_RST    = 16'd150;
  localparam ticks_t LOCKOUT_TICKS_RST = 16'd300;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_LOCKOUT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TONE_SILENT = 2'd0,
    TONE_LOW    = 2'd1,
    TONE_HIGH   = 2'd2
  } tone_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_DONE  = 2'd1,
    EV_WRONG = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    REG_CODE_FIRST  = 3'd0,
    REG_CODE_SECOND = 3'd1,
    REG_CODE_THIRD  = 3'd2,
    REG_CODE_FOURTH = 3'd3,
    REG_CODE_FIFTH  = 3'd4,
    REG_BEEP        = 3'd5,
    REG_LOCKOUT     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    pads_field_t pad_down;
    logic [1:0]  command;
  } item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] tone;
    logic       white_flash;
    red_field_t red_mask;
    count_t     progress;
    logic [1:0] mode;
  } result_t;

  typedef struct packed {
    code_t [CODE_LEN-1:0] code;
    ticks_t               beep_ticks;
    ticks_t               lockout_ticks;
  } cfg_t;

  // register value clipped to what the timer can count to
  function automatic timer_t limit_of(ticks_t ticks);
    logic [31:0] wide;
    wide = 32'(ticks);
    if (wide > 32'(TIMER_MAX)) return TIMER_MAX;
    return timer_t'(wide);
  endfunction

  function automatic timer_t count_up(timer_t v);
    if (v == TIMER_MAX) return v;
    return v + timer_t'(1);
  endfunction

endpackage

@@ rtl/keypad_code_sequence_lock_unit.sv @@
// Five-pad code lock. Each input item is a 1 ms tick carrying pad touch-down
// edges, an arm or a disarm command, and each item yields exactly one result
// item with mode, progress, red pad mask, white flash, tone and event. One item
// is taken per clock while the output is not stalled; the input register takes
// the item when it is accepted, and the lock state and result register update
// when it moves on, which a stalled output can hold off. Code and timer
// registers sit on the APB port and should be written only while no item is
// in flight.
`include "keypad_code_sequence_lock_unit_assert.svh"

module keypad_code_sequence_lock_unit (
  input  logic                             clk,
  input  logic                             rst,
  // s_tdata: command[1:0], pad_down[6:2], zero[7]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kcsl_pkg::IN_TDATA_W-1:0]  s_tdata,
  // m_tdata: mode[1:0], progress[4:2], red_mask[9:5], white_flash[10],
  // tone[12:11], event_res[14:13], zero[15]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [kcsl_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kcsl_pkg::APB_AW-1:0]      paddr,
  input  logic [kcsl_pkg::APB_DW-1:0]      pwdata,
  output logic [kcsl_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  kcsl_pkg::cfg_t    cfg;
  logic              in_valid;
  kcsl_pkg::item_t   in_item;
  logic              out_valid;
  kcsl_pkg::result_t out_res;
  kcsl_pkg::result_t res;
  logic              advance;

  kcsl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcsl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // item moves into the result register when that slot is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= kcsl_pkg::item_t'(s_tdata[6:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};

  `KCSL_ASSERT_NXT(a_result_after_step, clk, rst, advance,
                   out_valid && out_res == $past(res))
  `KCSL_ASSERT_IMP(a_done_goes_idle, clk, rst,
                   out_valid && out_res.event_res == kcsl_pkg::EV_DONE,
                   out_res.mode == kcsl_pkg::MODE_IDLE &&
                   out_res.progress == kcsl_pkg::COUNT_W'(kcsl_pkg::CODE_LEN))
  `KCSL_ASSERT_IMP(a_wrong_locks_out, clk, rst,
                   out_valid && out_res.event_res == kcsl_pkg::EV_WRONG,
                   out_res.mode == kcsl_pkg::MODE_LOCKOUT && out_res.progress == '0 &&
                   out_res.white_flash && out_res.tone == kcsl_pkg::TONE_HIGH)
  `KCSL_ASSERT_NXT(a_held_item_stays, clk, rst, in_valid && !advance,
                   in_valid && $stable(in_item))

endmodule

@@ rtl/kcsl_regs.sv @@
module kcsl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kcsl_pkg::APB_AW-1:0] paddr,
  input  logic [kcsl_pkg::APB_DW-1:0] pwdata,
  output logic [kcsl_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output kcsl_pkg::cfg_t              cfg
);

  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < kcsl_pkg::CODE_LEN; i++) begin
        cfg.code[i] <= kcsl_pkg::CODE_W'(i);
      end
      cfg.beep_ticks    <= kcsl_pkg::BEEP_TICKS_RST;
      cfg.lockout_ticks <= kcsl_pkg::LOCKOUT_TICKS_RST;
    end else if (wr_en) begin
      case (reg_sel) inside
        kcsl_pkg::REG_CODE_FIRST, kcsl_pkg::REG_CODE_SECOND, kcsl_pkg::REG_CODE_THIRD,
        kcsl_pkg::REG_CODE_FOURTH, kcsl_pkg::REG_CODE_FIFTH: begin
          cfg.code[reg_sel] <= pwdata[kcsl_pkg::CODE_W-1:0];
        end
        kcsl_pkg::REG_BEEP: begin
          cfg.beep_ticks <= pwdata[kcsl_pkg::TICKS_W-1:0];
        end
        kcsl_pkg::REG_LOCKOUT: begin
          cfg.lockout_ticks <= pwdata[kcsl_pkg::TICKS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel) inside
      kcsl_pkg::REG_CODE_FIRST, kcsl_pkg::REG_CODE_SECOND, kcsl_pkg::REG_CODE_THIRD,
      kcsl_pkg::REG_CODE_FOURTH, kcsl_pkg::REG_CODE_FIFTH: begin
        prdata = kcsl_pkg::APB_DW'(cfg.code[reg_sel]);
      end
      kcsl_pkg::REG_BEEP:    prdata = kcsl_pkg::APB_DW'(cfg.beep_ticks);
      kcsl_pkg::REG_LOCKOUT: prdata = kcsl_pkg::APB_DW'(cfg.lockout_ticks);
      default:               prdata = '0;
    endcase
  end

endmodule

@@ rtl/kcsl_core.sv @@
module kcsl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  kcsl_pkg::item_t   item,
  input  kcsl_pkg::cfg_t    cfg,
  output kcsl_pkg::result_t res
);

  kcsl_pkg::mode_t     mode, mode_next;
  kcsl_pkg::count_t    count, count_next;
  logic                beep_active, beep_active_next;
  kcsl_pkg::timer_t    beep_elapsed, beep_elapsed_next;
  kcsl_pkg::timer_t    lockout_elapsed, lockout_elapsed_next;
  kcsl_pkg::tone_t     tone, tone_next;
  kcsl_pkg::pad_mask_t lit_red, lit_red_next;
  logic                lit_white, lit_white_next;
  kcsl_pkg::event_t    ev;

  kcsl_pkg::pad_mask_t pads;
  kcsl_pkg::code_t     pad_idx;
  logic                hit;
  logic                match;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= kcsl_pkg::MODE_IDLE;
      count           <= '0;
      beep_active     <= 1'b0;
      beep_elapsed    <= '0;
      lockout_elapsed <= '0;
      tone            <= kcsl_pkg::TONE_SILENT;
      lit_red         <= '0;
      lit_white       <= 1'b0;
    end else if (step) begin
      mode            <= mode_next;
      count           <= count_next;
      beep_active     <= beep_active_next;
      beep_elapsed    <= beep_elapsed_next;
      lockout_elapsed <= lockout_elapsed_next;
      tone            <= tone_next;
      lit_red         <= lit_red_next;
      lit_white       <= lit_white_next;
    end
  end

  // lowest pressed pad wins
  always_comb begin
    pads    = kcsl_pkg::pad_mask_t'(item.pad_down);
    pad_idx = '0;
    hit     = 1'b0;
    for (int i = kcsl_pkg::PAD_COUNT - 1; i >= 0; i--) begin
      if (pads[i]) begin
        pad_idx = kcsl_pkg::CODE_W'(i);
        hit     = 1'b1;
      end
    end
    match = (count < kcsl_pkg::COUNT_W'(kcsl_pkg::CODE_LEN)) && (pad_idx == cfg.code[count]);
  end

  always_comb begin
    mode_next            = mode;
    count_next           = count;
    beep_active_next     = beep_active;
    beep_elapsed_next    = beep_elapsed;
    lockout_elapsed_next = lockout_elapsed;
    tone_next            = tone;
    lit_red_next         = lit_red;
    lit_white_next       = lit_white;
    ev                   = kcsl_pkg::EV_NONE;

    case (kcsl_pkg::cmd_t'(item.command))
      kcsl_pkg::CMD_TICK: begin
        if (beep_active) begin
          beep_elapsed_next = kcsl_pkg::count_up(beep_elapsed);
          if (beep_elapsed_next >= kcsl_pkg::limit_of(cfg.beep_ticks)) begin
            tone_next        = kcsl_pkg::TONE_SILENT;
            beep_active_next = 1'b0;
          end
        end
        if (mode == kcsl_pkg::MODE_LOCKOUT) begin
          lockout_elapsed_next = kcsl_pkg::count_up(lockout_elapsed);
          if (lockout_elapsed_next >= kcsl_pkg::limit_of(cfg.lockout_ticks)) begin
            tone_next      = kcsl_pkg::TONE_SILENT;
            mode_next      = kcsl_pkg::MODE_ACTIVE;
            lit_red_next   = kcsl_pkg::ALL_PADS;
            lit_white_next = 1'b0;
          end
        end else if (mode == kcsl_pkg::MODE_ACTIVE && hit) begin
          if (match) begin
            for (int i = 0; i < kcsl_pkg::PAD_COUNT; i++) begin
              if (pad_idx == kcsl_pkg::CODE_W'(i)) lit_red_next[i] = 1'b0;
            end
            tone_next         = kcsl_pkg::TONE_LOW;
            beep_active_next  = 1'b1;
            beep_elapsed_next = '0;
            count_next        = count + kcsl_pkg::count_t'(1);
            if (count_next == kcsl_pkg::COUNT_W'(kcsl_pkg::CODE_LEN)) begin
              mode_next = kcsl_pkg::MODE_IDLE;
              ev        = kcsl_pkg::EV_DONE;
            end
          end else begin
            lit_red_next         = '0;
            lit_white_next       = 1'b1;
            tone_next            = kcsl_pkg::TONE_HIGH;
            lockout_elapsed_next = '0;
            mode_next            = kcsl_pkg::MODE_LOCKOUT;
            count_next           = '0;
            ev                   = kcsl_pkg::EV_WRONG;
          end
        end
      end
      kcsl_pkg::CMD_ARM: begin
        count_next           = '0;
        beep_active_next     = 1'b0;
        tone_next            = kcsl_pkg::TONE_SILENT;
        mode_next            = kcsl_pkg::MODE_ACTIVE;
        lit_red_next         = kcsl_pkg::ALL_PADS;
        lit_white_next       = 1'b0;
        lockout_elapsed_next = '0;
      end
      kcsl_pkg::CMD_DISARM: begin
        mode_next = kcsl_pkg::MODE_IDLE;
        if (beep_active) begin
          tone_next        = kcsl_pkg::TONE_SILENT;
          beep_active_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.mode        = mode_next;
    res.progress    = count_next;
    res.red_mask    = kcsl_pkg::red_field_t'(lit_red_next);
    res.white_flash = lit_white_next;
    res.tone        = tone_next;
    res.event_res   = ev;
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kcsl_pkg::*;

  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 238;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // pad_down, command
  localparam item_t DIRECTED [25] = '{
    '{5'h1F, CMD_TICK},     // pads while idle are ignored
    '{5'h1F, CMD_RESERVED},
    '{5'h00, CMD_DISARM},
    '{5'h00, CMD_ARM},
    '{5'h00, CMD_TICK},
    '{5'h02, CMD_TICK},     // first code pad
    '{5'h18, CMD_TICK},     // only the lowest pad counts
    '{5'h00, CMD_TICK},
    '{5'h01, CMD_TICK},
    '{5'h10, CMD_TICK},
    '{5'h1C, CMD_TICK},     // fifth pad completes the code
    '{5'h00, CMD_TICK},
    '{5'h00, CMD_TICK},     // beep still runs out after success
    '{5'h00, CMD_TICK},
    '{5'h00, CMD_ARM},
    '{5'h02, CMD_TICK},
    '{5'h04, CMD_TICK},     // wrong pad while the beep runs
    '{5'h02, CMD_TICK},     // beep expiry cuts the error tone
    '{5'h1F, CMD_TICK},
    '{5'h00, CMD_TICK},
    '{5'h00, CMD_TICK},     // lockout over, pads red again
    '{5'h1E, CMD_TICK},
    '{5'h00, CMD_DISARM},   // disarm stops the beep
    '{5'h00, CMD_ARM},
    '{5'h00, CMD_RESERVED}
  };

  class lock_scoreboard;
    code_t     code [CODE_LEN];
    ticks_t    beep_len;
    ticks_t    lockout_len;
    mode_t     mode;
    count_t    entered;
    bit        beep_on;
    timer_t    beep_count;
    timer_t    lockout_count;
    tone_t     tone;
    pad_mask_t red;
    bit        white;
    result_t   expected_q [$];
    int        errors;

    function new();
      for (int i = 0; i < CODE_LEN; i++) code[i] = code_t'(i);
      beep_len = BEEP_TICKS_RST;
      lockout_len = LOCKOUT_TICKS_RST;
      mode = MODE_IDLE;
      entered = '0;
      beep_on = 1'b0;
      beep_count = '0;
      lockout_count = '0;
      tone = TONE_SILENT;
      red = '0;
      white = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_BEEP:    beep_len = value[TICKS_W-1:0];
        REG_LOCKOUT: lockout_len = value[TICKS_W-1:0];
        default:     code[int'(idx)] = value[CODE_W-1:0];
      endcase
    endfunction

    function void note_item(item_t it);
      result_t   want;
      event_t    ev;
      pad_mask_t pads;
      int        pad;
      ev = EV_NONE;
      case (it.command)
        CMD_TICK: begin
          // beep timer runs in every mode, so it can end an error tone too
          if (beep_on) begin
            if (beep_count != TIMER_MAX) beep_count++;
            if (beep_count >= beep_len) begin
              tone = TONE_SILENT;
              beep_on = 1'b0;
            end
          end
          if (mode == MODE_LOCKOUT) begin
            if (lockout_count != TIMER_MAX) lockout_count++;
            if (lockout_count >= lockout_len) begin
              tone = TONE_SILENT;
              mode = MODE_ACTIVE;
              red = ALL_PADS;
              white = 1'b0;
            end
          end else if (mode == MODE_ACTIVE && (it.pad_down & ALL_PADS) != '0) begin
            pads = it.pad_down & ALL_PADS;
            pad = 0;
            for (int i = PAD_COUNT - 1; i >= 0; i--) if (pads[i]) pad = i;
            if (entered < CODE_LEN && pad == int'(code[entered])) begin
              red[pad] = 1'b0;
              tone = TONE_LOW;
              beep_on = 1'b1;
              beep_count = '0;
              entered++;
              if (entered == CODE_LEN) begin
                mode = MODE_IDLE;
                ev = EV_DONE;
              end
            end else begin
              red = '0;
              white = 1'b1;
              tone = TONE_HIGH;
              lockout_count = '0;
              mode = MODE_LOCKOUT;
              entered = '0;
              ev = EV_WRONG;
            end
          end
        end
        CMD_ARM: begin
          entered = '0;
          beep_on = 1'b0;
          tone = TONE_SILENT;
          mode = MODE_ACTIVE;
          red = ALL_PADS;
          white = 1'b0;
          lockout_count = '0;
        end
        CMD_DISARM: begin
          // leds and progress stay as they are; the tone is cut only while the beep runs
          mode = MODE_IDLE;
          if (beep_on) begin
            tone = TONE_SILENT;
            beep_on = 1'b0;
          end
        end
        default: ;
      endcase
      want.mode = mode;
      want.progress = entered;
      want.red_mask = red;
      want.white_flash = white;
      want.tone = tone;
      want.event_res = ev;
      expected_q.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result item %h with nothing expected", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.mode != want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        errors++;
      end
      if (got.progress != want.progress) begin
        $error("progress: expected %0d, got %0d", want.progress, got.progress);
        errors++;
      end
      if (got.red_mask != want.red_mask) begin
        $error("red_mask: expected %h, got %h", want.red_mask, got.red_mask);
        errors++;
      end
      if (got.white_flash != want.white_flash) begin
        $error("white_flash: expected %0d, got %0d", want.white_flash, got.white_flash);
        errors++;
      end
      if (got.tone != want.tone) begin
        $error("tone: expected %0d, got %0d", want.tone, got.tone);
        errors++;
      end
      if (got.event_res != want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [APB_DW-1:0]      pwdata;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  lock_scoreboard sb = new();
  int unsigned cycles = 0;
  int feed_left = 0;
  bit feed_calm = 1'b0;
  int drain_left = 0;
  bit drain_calm = 1'b0;

  keypad_code_sequence_lock_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stretches of back-to-back items alternate with random waits
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic program_lock(input cfg_t cfg);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < CODE_LEN; i++) apb_write(reg_idx_t'(i), APB_DW'(cfg.code[i]));
    apb_write(REG_BEEP, APB_DW'(cfg.beep_ticks));
    apb_write(REG_LOCKOUT, APB_DW'(cfg.lockout_ticks));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait(feed_left, feed_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'(it);
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
  endtask

  function automatic cfg_t pick_cfg(int phase);
    cfg_t cfg;
    for (int i = 0; i < CODE_LEN; i++) cfg.code[i] = code_t'($urandom_range(0, PAD_COUNT - 1));
    cfg.beep_ticks = ticks_t'($urandom_range(0, 12));
    cfg.lockout_ticks = ticks_t'($urandom_range(0, 20));
    case (phase)
      0: begin
        cfg.beep_ticks = '0;
        cfg.lockout_ticks = '0;
      end
      1: begin
        cfg.beep_ticks = '1;
        cfg.lockout_ticks = '1;
      end
      2: begin
        cfg.beep_ticks = ticks_t'(1);
        cfg.lockout_ticks = ticks_t'(1);
      end
      // an entry that names no pad makes every press there wrong
      3: cfg.code[$urandom_range(0, CODE_LEN - 1)] = '1;
      4: cfg.code[$urandom_range(0, CODE_LEN - 1)] = code_t'($urandom_range(PAD_COUNT, 7));
      default: ;
    endcase
    return cfg;
  endfunction

  // mostly correct code entry once armed, with noise and broken sequences
  function automatic item_t pick_item();
    item_t     it;
    int        r;
    int        p;
    pad_mask_t above;
    r = $urandom_range(0, 99);
    it.command = CMD_TICK;
    it.pad_down = pads_field_t'($urandom_range(0, 31));
    case (sb.mode)
      MODE_ACTIVE: begin
        if (r < 55) begin
          p = (sb.entered < CODE_LEN) ? int'(sb.code[sb.entered]) : PAD_COUNT;
          if (p < PAD_COUNT) begin
            above = pad_mask_t'($urandom_range(0, 31)) & ~pad_mask_t'((2 << p) - 1);
            it.pad_down = above | pad_mask_t'(1 << p);
          end
        end else if (r < 75) begin
          it.pad_down = '0;
        end else if (r < 79) begin
          it.command = CMD_ARM;
        end else if (r < 82) begin
          it.command = CMD_DISARM;
        end else if (r < 85) begin
          it.command = CMD_RESERVED;
        end
      end
      MODE_LOCKOUT: begin
        if (r < 15) it.command = CMD_ARM;
        else if (r < 20) it.command = CMD_DISARM;
        else if (r < 25) it.command = CMD_RESERVED;
      end
      default: begin
        if (r < 50) it.command = CMD_ARM;
        else if (r < 60) it.command = CMD_DISARM;
        else if (r < 65) it.command = CMD_RESERVED;
      end
    endcase
    return it;
  endfunction

  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(drain_left, drain_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(result_t'(m_tdata[$bits(result_t)-1:0]));
    end
  end

  initial begin
    cfg_t cfg;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg.code[0] = code_t'(1);
    cfg.code[1] = code_t'(3);
    cfg.code[2] = code_t'(0);
    cfg.code[3] = code_t'(4);
    cfg.code[4] = code_t'(2);
    cfg.beep_ticks = ticks_t'(2);
    cfg.lockout_ticks = ticks_t'(4);
    program_lock(cfg);
    foreach (DIRECTED[i]) send_item(DIRECTED[i]);
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_lock(pick_cfg(ph));
      repeat (PHASE_ITEMS) send_item(pick_item());
      s_tvalid <= 1'b0;
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ keypad_code_sequence_lock_unit.f @@
+incdir+rtl
rtl/kcsl_pkg.sv
rtl/kcsl_regs.sv
rtl/kcsl_core.sv
rtl/keypad_code_sequence_lock_unit.sv
tb/testbench.sv
